// ===== rtl/assert_macros.svh =====
// assertion macros shared by the scan rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mbps_pkg.sv =====
// package with shared constants, register codes and types of the byte pattern scan
package mbps_pkg;

   localparam int MAX_PATTERN_DEFAULT    = 16;
   localparam int POSITION_WIDTH_DEFAULT = 32;
   localparam int PATTERN_BYTES          = 16;
   localparam int LEN_WIDTH              = 5;
   localparam int STRIDE_WIDTH           = 8;
   localparam int ADDR_WIDTH             = 48;
   localparam int CSR_DATA_WIDTH         = 64;
   localparam int CSR_ADDR_WIDTH         = 6;

   typedef enum logic [2:0] {
      REG_PATTERN_LOW    = 3'd0,
      REG_PATTERN_HIGH   = 3'd1,
      REG_WILDCARD_MASK  = 3'd2,
      REG_PAT_LEN        = 3'd3,
      REG_STRIDE         = 3'd4,
      REG_BASE_ADDRESS   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [8*PATTERN_BYTES-1:0] pattern;
      logic [PATTERN_BYTES-1:0]   wildcard_mask;
      logic [LEN_WIDTH-1:0]       pat_len;
      logic [STRIDE_WIDTH-1:0]    stride;
      logic [ADDR_WIDTH-1:0]      base_address;
   } cfg_type;

   typedef struct packed {
      logic                 shift;
      logic                 clear;
      logic [LEN_WIDTH-1:0] used_len;
   } cell_ctrl_type;

endpackage

// ===== rtl/mbps_regs.sv =====
// configuration register file behind the apb-style port
module mbps_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output mbps_pkg::cfg_type                    cfg
);

   logic [63:0]                           pattern_low_ff, pattern_low_in;
   logic [63:0]                           pattern_high_ff, pattern_high_in;
   logic [mbps_pkg::PATTERN_BYTES-1:0]    wildcard_ff, wildcard_in;
   logic [mbps_pkg::LEN_WIDTH-1:0]        length_ff, length_in;
   logic [mbps_pkg::STRIDE_WIDTH-1:0]     stride_ff, stride_in;
   logic [mbps_pkg::ADDR_WIDTH-1:0]       base_ff, base_in;
   logic                                  wr_en;
   mbps_pkg::reg_index_type               reg_sel;

   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel = mbps_pkg::reg_index_type'(csr_paddr[5:3]);

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      wildcard_in     = wildcard_ff;
      length_in       = length_ff;
      stride_in       = stride_ff;
      base_in         = base_ff;
      csr_prdata      = '0;
      unique case (reg_sel)
         mbps_pkg::REG_PATTERN_LOW: begin
            csr_prdata = pattern_low_ff;
            if (wr_en) pattern_low_in = csr_pwdata;
         end
         mbps_pkg::REG_PATTERN_HIGH: begin
            csr_prdata = pattern_high_ff;
            if (wr_en) pattern_high_in = csr_pwdata;
         end
         mbps_pkg::REG_WILDCARD_MASK: begin
            csr_prdata = mbps_pkg::CSR_DATA_WIDTH'(wildcard_ff);
            if (wr_en) wildcard_in = csr_pwdata[mbps_pkg::PATTERN_BYTES-1:0];
         end
         mbps_pkg::REG_PAT_LEN: begin
            csr_prdata = mbps_pkg::CSR_DATA_WIDTH'(length_ff);
            if (wr_en) length_in = csr_pwdata[mbps_pkg::LEN_WIDTH-1:0];
         end
         mbps_pkg::REG_STRIDE: begin
            csr_prdata = mbps_pkg::CSR_DATA_WIDTH'(stride_ff);
            if (wr_en) stride_in = csr_pwdata[mbps_pkg::STRIDE_WIDTH-1:0];
         end
         mbps_pkg::REG_BASE_ADDRESS: begin
            csr_prdata = mbps_pkg::CSR_DATA_WIDTH'(base_ff);
            if (wr_en) base_in = csr_pwdata[mbps_pkg::ADDR_WIDTH-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         wildcard_ff     <= '0;
         length_ff       <= mbps_pkg::LEN_WIDTH'(1);
         stride_ff       <= mbps_pkg::STRIDE_WIDTH'(1);
         base_ff         <= '0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         wildcard_ff     <= wildcard_in;
         length_ff       <= length_in;
         stride_ff       <= stride_in;
         base_ff         <= base_in;
      end
   end

   assign cfg.pattern        = {pattern_high_ff, pattern_low_ff};
   assign cfg.wildcard_mask  = wildcard_ff;
   assign cfg.pat_len        = length_ff;
   assign cfg.stride         = stride_ff;
   assign cfg.base_address   = base_ff;

endmodule

// ===== rtl/mbps_cell.sv =====
// one window cell: holds a byte and its start flag, compares the incoming byte
`include "assert_macros.svh"

module mbps_cell #(
   parameter int INDEX = 0
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mbps_pkg::cell_ctrl_type                 ctrl,
   input  logic [8*mbps_pkg::PATTERN_BYTES-1:0]    pattern,
   input  logic [mbps_pkg::PATTERN_BYTES-1:0]      wildcard_mask,
   input  logic [7:0]                              byte_in,
   input  logic                                    elig_in,
   output logic [7:0]                              byte_out,
   output logic                                    elig_out,
   output logic                                    hit
);

   logic [7:0]                       byte_ff, byte_next_in;
   logic                             elig_ff, elig_next_in;
   logic                             active;
   logic [mbps_pkg::LEN_WIDTH-1:0]   pat_pos;
   logic [3:0]                       pat_idx;
   logic [7:0]                       pat_byte;

   // this cell sees pattern byte used_len-1-INDEX once the new word is shifted in
   assign active   = mbps_pkg::LEN_WIDTH'(INDEX) < ctrl.used_len;
   assign pat_pos  = ctrl.used_len - mbps_pkg::LEN_WIDTH'(1) - mbps_pkg::LEN_WIDTH'(INDEX);
   assign pat_idx  = pat_pos[3:0];
   assign pat_byte = pattern[pat_idx*8 +: 8];
   assign hit      = !active || wildcard_mask[pat_idx] || (byte_in == pat_byte);

   always_comb begin
      byte_next_in = byte_ff;
      elig_next_in = elig_ff;
      if (ctrl.clear) begin
         byte_next_in = '0;
         elig_next_in = 1'b0;
      end else if (ctrl.shift) begin
         byte_next_in = byte_in;
         elig_next_in = elig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
         elig_ff <= 1'b0;
      end else begin
         byte_ff <= byte_next_in;
         elig_ff <= elig_next_in;
      end
   end

   assign byte_out = byte_ff;
   assign elig_out = elig_ff;

   `ASSERT_NEXT(a_clear_drops_flag, clock, reset, ctrl.clear, !elig_ff, "cell start flag survived a clear")

endmodule

// ===== rtl/masked_byte_pattern_search_unit.sv =====
// masked byte pattern scan: one data byte per cycle through a chain of window cells
// latency: the result word is registered and appears in the cycle after the last byte is taken
// throughput: one byte per cycle while no result word is held; every cell compares its byte in parallel
// a pending result stalls input only while rsp_tready is low and holds the output register
// reset (synchronous) clears scan state and returns all registers but result found/address to reset values
`include "assert_macros.svh"

module masked_byte_pattern_search_unit #(
   parameter int MAX_PATTERN    = mbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int POSITION_WIDTH = mbps_pkg::POSITION_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: data_byte[7:0]
   input  logic [7:0]                           req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: found[0], match_address[48:1], zero pad[55:49]
   output logic [55:0]                          rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int CELL_COUNT = (MAX_PATTERN < mbps_pkg::PATTERN_BYTES) ?
                               MAX_PATTERN : mbps_pkg::PATTERN_BYTES;
   localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int AW         = mbps_pkg::ADDR_WIDTH;

   mbps_pkg::cfg_type                  cfg;
   mbps_pkg::cell_ctrl_type            ctrl;

   logic                               accept, last_accept;
   logic [mbps_pkg::LEN_WIDTH-1:0]     used_len;
   logic [IDX_W-1:0]                   sel_idx;
   logic [7:0]                         byte_chain [0:CELL_COUNT-1];
   logic                               elig_chain [0:CELL_COUNT-1];
   logic [CELL_COUNT-1:0]              hit;
   logic                               window_hit;

   logic [mbps_pkg::STRIDE_WIDTH-1:0]  phase_ff, phase_in;
   logic [mbps_pkg::STRIDE_WIDTH-1:0]  eff_stride;
   logic [mbps_pkg::STRIDE_WIDTH:0]    phase_inc;
   logic [POSITION_WIDTH-1:0]          pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0]          cur_offset;
   logic                               match_seen_ff, match_seen_in;
   logic [POSITION_WIDTH-1:0]          first_off_ff, first_off_in;

   logic                               found;
   logic [POSITION_WIDTH-1:0]          res_offset;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [AW-1:0]                      rsp_addr_ff, rsp_addr_in;

   mbps_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   // length zero reads as one, longer than the chain saturates
   always_comb begin
      used_len = cfg.pat_len;
      if (used_len == '0) begin
         used_len = mbps_pkg::LEN_WIDTH'(1);
      end else if (used_len > mbps_pkg::LEN_WIDTH'(CELL_COUNT)) begin
         used_len = mbps_pkg::LEN_WIDTH'(CELL_COUNT);
      end
   end

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign last_accept = accept && req_tlast;

   assign ctrl.shift    = accept;
   assign ctrl.clear    = last_accept;
   assign ctrl.used_len = used_len;

   assign byte_chain[0] = req_tdata;
   assign elig_chain[0] = (phase_ff == '0);

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      if (k < CELL_COUNT - 1) begin : g_mid
         mbps_cell #(.INDEX(k)) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (ctrl),
            .pattern       (cfg.pattern),
            .wildcard_mask (cfg.wildcard_mask),
            .byte_in       (byte_chain[k]),
            .elig_in       (elig_chain[k]),
            .byte_out      (byte_chain[k+1]),
            .elig_out      (elig_chain[k+1]),
            .hit           (hit[k])
         );
      end else begin : g_end
         mbps_cell #(.INDEX(k)) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctrl          (ctrl),
            .pattern       (cfg.pattern),
            .wildcard_mask (cfg.wildcard_mask),
            .byte_in       (byte_chain[k]),
            .elig_in       (elig_chain[k]),
            .byte_out      (),
            .elig_out      (),
            .hit           (hit[k])
         );
      end
   end

   // window start flag sits in the cell at used_len-1 after the shift
   assign sel_idx    = IDX_W'(used_len - mbps_pkg::LEN_WIDTH'(1));
   assign window_hit = elig_chain[sel_idx] && (&hit);

   assign eff_stride = (cfg.stride == '0) ? mbps_pkg::STRIDE_WIDTH'(1) : cfg.stride;
   assign phase_inc  = {1'b0, phase_ff} + (mbps_pkg::STRIDE_WIDTH+1)'(1);
   assign cur_offset = pos_ff - POSITION_WIDTH'(used_len - mbps_pkg::LEN_WIDTH'(1));

   assign found      = match_seen_ff || window_hit;
   assign res_offset = match_seen_ff ? first_off_ff : cur_offset;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      match_seen_in = match_seen_ff;
      first_off_in  = first_off_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (last_accept) begin
         phase_in      = '0;
         pos_in        = '0;
         match_seen_in = 1'b0;
         first_off_in  = '0;
         rsp_valid_in  = 1'b1;
         rsp_found_in  = found;
         rsp_addr_in   = found ? (cfg.base_address + AW'(res_offset)) : '0;
      end else if (accept) begin
         phase_in = (phase_inc >= {1'b0, eff_stride}) ? '0 :
                    phase_inc[mbps_pkg::STRIDE_WIDTH-1:0];
         pos_in   = pos_ff + POSITION_WIDTH'(1);
         if (!match_seen_ff && window_hit) begin
            match_seen_in = 1'b1;
            first_off_in  = cur_offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
      if (reset) begin
         phase_ff      <= '0;
         pos_ff        <= '0;
         match_seen_ff <= 1'b0;
         first_off_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         match_seen_ff <= match_seen_in;
         first_off_ff  <= first_off_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_addr_ff, rsp_found_ff};

   `ASSERT_IMPL(a_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready, "input taken while result word is held")
   `ASSERT_IMPL(a_no_match_zero_addr, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_addr_ff == '0, "address set on a miss")
   `ASSERT_NEXT(a_region_end_clears, clock, reset, last_accept, pos_ff == '0 && !match_seen_ff && phase_ff == '0, "scan state not cleared after last word")
   `ASSERT_NEXT(a_last_gives_result, clock, reset, last_accept, rsp_valid_ff, "no result word after last word")

endmodule
